[design/rpc_pkg.sv]
// shared types, register map and reset values for the rc pulse capture block
package rpc_pkg;

  localparam int CHANNELS_DEFAULT = 4;

  localparam int CAP_W   = 16;
  localparam int VAL_W   = 12;
  localparam int TICK_W  = 8;
  localparam int PORT_W  = 2;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 3;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET  = 8'd5;
  localparam logic [VAL_W-1:0]  MIN_RESET      = 12'd900;
  localparam logic [VAL_W-1:0]  MAX_RESET      = 12'd2050;
  localparam logic [VAL_W-1:0]  THROTTLE_RESET = 12'd1000;
  localparam logic [VAL_W-1:0]  CENTER_RESET   = 12'd1500;
  localparam logic [PORT_W-1:0] THR_CH_RESET   = 2'd1;

  typedef enum logic [IDX_W-1:0] {
    REG_TIMEOUT_TICKS    = 3'd0,
    REG_MIN_ACCEPT       = 3'd1,
    REG_MAX_ACCEPT       = 3'd2,
    REG_THROTTLE_DEFAULT = 3'd3,
    REG_CENTER_DEFAULT   = 3'd4,
    REG_THROTTLE_CHANNEL = 3'd5
  } reg_idx_t;

  typedef enum logic {
    OP_CAPTURE = 1'b0,
    OP_TICK    = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [TICK_W-1:0] timeout_ticks;
    logic [VAL_W-1:0]  min_accept;
    logic [VAL_W-1:0]  max_accept;
    logic [VAL_W-1:0]  throttle_default;
    logic [VAL_W-1:0]  center_default;
    logic [PORT_W-1:0] throttle_channel;
  } cfg_t;

  typedef struct packed {
    logic             opcode;
    logic [CAP_W-1:0] capture_time;
  } in_word_t;

  typedef struct packed {
    logic              stored;
    logic [PORT_W-1:0] written_channel;
    logic [VAL_W-1:0]  width_us;
    logic [PORT_W-1:0] mux_select;
    logic              timed_out;
    logic              await_rising;
  } out_word_t;

endpackage

[design/rpc_cfg_regs.sv]
// apb configuration register file
module rpc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [rpc_pkg::DATA_W-1:0]   pwdata,
  output logic [rpc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output rpc_pkg::cfg_t                cfg
);

  rpc_pkg::reg_idx_t idx;

  assign idx    = rpc_pkg::reg_idx_t'(paddr[rpc_pkg::ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks    <= rpc_pkg::TIMEOUT_RESET;
      cfg.min_accept       <= rpc_pkg::MIN_RESET;
      cfg.max_accept       <= rpc_pkg::MAX_RESET;
      cfg.throttle_default <= rpc_pkg::THROTTLE_RESET;
      cfg.center_default   <= rpc_pkg::CENTER_RESET;
      cfg.throttle_channel <= rpc_pkg::THR_CH_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        rpc_pkg::REG_TIMEOUT_TICKS:    cfg.timeout_ticks    <= pwdata[rpc_pkg::TICK_W-1:0];
        rpc_pkg::REG_MIN_ACCEPT:       cfg.min_accept       <= pwdata[rpc_pkg::VAL_W-1:0];
        rpc_pkg::REG_MAX_ACCEPT:       cfg.max_accept       <= pwdata[rpc_pkg::VAL_W-1:0];
        rpc_pkg::REG_THROTTLE_DEFAULT: cfg.throttle_default <= pwdata[rpc_pkg::VAL_W-1:0];
        rpc_pkg::REG_CENTER_DEFAULT:   cfg.center_default   <= pwdata[rpc_pkg::VAL_W-1:0];
        rpc_pkg::REG_THROTTLE_CHANNEL: cfg.throttle_channel <= pwdata[rpc_pkg::PORT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      rpc_pkg::REG_TIMEOUT_TICKS:    prdata = rpc_pkg::DATA_W'(cfg.timeout_ticks);
      rpc_pkg::REG_MIN_ACCEPT:       prdata = rpc_pkg::DATA_W'(cfg.min_accept);
      rpc_pkg::REG_MAX_ACCEPT:       prdata = rpc_pkg::DATA_W'(cfg.max_accept);
      rpc_pkg::REG_THROTTLE_DEFAULT: prdata = rpc_pkg::DATA_W'(cfg.throttle_default);
      rpc_pkg::REG_CENTER_DEFAULT:   prdata = rpc_pkg::DATA_W'(cfg.center_default);
      rpc_pkg::REG_THROTTLE_CHANNEL: prdata = rpc_pkg::DATA_W'(cfg.throttle_channel);
      default:                       prdata = '0;
    endcase
  end

endmodule

[design/rpc_engine.sv]
// edge timing, width check, stall timeout and channel sequencing
module rpc_engine #(
  parameter int CHANNELS = rpc_pkg::CHANNELS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  rpc_pkg::in_word_t  word,
  input  rpc_pkg::cfg_t      cfg,
  output rpc_pkg::out_word_t res
);

  localparam int ChW  = $clog2(CHANNELS);
  localparam int CmpW = (ChW > rpc_pkg::PORT_W) ? ChW : rpc_pkg::PORT_W;
  localparam logic [ChW-1:0] LastCh = ChW'(CHANNELS - 1);

  logic [ChW-1:0]             cur_ch, cur_ch_next, last_ch, last_ch_next, inc_ch;
  logic                       rising, rising_next;
  logic [rpc_pkg::CAP_W-1:0]  pulse_start, pulse_start_next, diff;
  logic [rpc_pkg::TICK_W-1:0] stall, stall_next;
  logic [rpc_pkg::CAP_W-2:0]  width;
  logic                       fits, is_throttle;

  assign inc_ch      = (cur_ch == LastCh) ? '0 : cur_ch + 1'b1;
  assign diff        = word.capture_time - pulse_start;
  assign width       = diff[rpc_pkg::CAP_W-1:1];
  assign fits        = (width <= (rpc_pkg::CAP_W-1)'(cfg.max_accept)) &&
                       (width >  (rpc_pkg::CAP_W-1)'(cfg.min_accept));
  assign is_throttle = CmpW'(cur_ch) == CmpW'(cfg.throttle_channel);

  always_comb begin
    cur_ch_next      = cur_ch;
    last_ch_next     = last_ch;
    rising_next      = rising;
    pulse_start_next = pulse_start;
    stall_next       = stall;
    res              = '0;
    if (word.opcode == rpc_pkg::OP_CAPTURE) begin
      if (rising) begin
        pulse_start_next = word.capture_time;
        rising_next      = 1'b0;
      end else begin
        rising_next = 1'b1;
        if (fits) begin
          res.stored          = 1'b1;
          res.written_channel = rpc_pkg::PORT_W'(cur_ch);
          res.width_us        = width[rpc_pkg::VAL_W-1:0];
          cur_ch_next         = inc_ch;
        end
      end
    end else begin
      if (last_ch != cur_ch) begin
        stall_next   = '0;
        last_ch_next = cur_ch;
      end else begin
        stall_next = stall + 1'b1;
        if (stall_next > cfg.timeout_ticks) begin
          res.stored          = 1'b1;
          res.timed_out       = 1'b1;
          res.written_channel = rpc_pkg::PORT_W'(cur_ch);
          res.width_us        = is_throttle ? cfg.throttle_default : cfg.center_default;
          cur_ch_next         = inc_ch;
          rising_next         = 1'b1;
        end
      end
    end
    res.mux_select   = rpc_pkg::PORT_W'(cur_ch_next);
    res.await_rising = rising_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_ch      <= '0;
      last_ch     <= '0;
      rising      <= 1'b1;
      pulse_start <= '0;
      stall       <= '0;
    end else if (advance) begin
      cur_ch      <= cur_ch_next;
      last_ch     <= last_ch_next;
      rising      <= rising_next;
      pulse_start <= pulse_start_next;
      stall       <= stall_next;
    end
  end

  a_timeout_stores: assert property (@(posedge clk) disable iff (rst)
    advance && res.timed_out |-> res.stored)
    else $error("timeout without a store");

  a_width_in_window: assert property (@(posedge clk) disable iff (rst)
    advance && res.stored && !res.timed_out |->
      res.width_us > cfg.min_accept && res.width_us <= cfg.max_accept)
    else $error("stored width outside acceptance window");

  a_no_store_zero: assert property (@(posedge clk) disable iff (rst)
    advance && !res.stored |-> res.width_us == '0 && res.written_channel == '0)
    else $error("fields set without a store");

  a_rising_arms: assert property (@(posedge clk) disable iff (rst)
    advance && word.opcode == rpc_pkg::OP_CAPTURE && rising |=> !rising)
    else $error("rising capture did not arm falling edge");

endmodule

[design/rc_pulse_capture_with_timeout_core.sv]
// top level: input register, capture engine, result register and config port
// Measures rc receiver pulse widths on one shared capture pin. Every word, capture or tick,
// yields one result word. Each word is held in the input register and is evaluated by the
// engine into the result register when that register is free or being taken, so one word
// can be taken every cycle while results are taken. Configuration is to be written over
// apb by the user only while idle; the block itself does not enforce it.
module rc_pulse_capture_with_timeout_core #(
  parameter int CHANNELS = rpc_pkg::CHANNELS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  rpc_pkg::in_word_t            in_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rpc_pkg::out_word_t           out_word,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [rpc_pkg::DATA_W-1:0]   pwdata,
  output logic [rpc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  rpc_pkg::cfg_t      cfg;
  rpc_pkg::in_word_t  in_q;
  rpc_pkg::out_word_t res;
  logic               in_q_valid, advance;

  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  rpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rpc_engine #(.CHANNELS(CHANNELS)) u_engine (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .word    (in_q),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_q_valid <= 1'b1;
      end else if (advance) begin
        in_q_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_word;
    end
    if (advance) begin
      out_word <= res;
    end
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// testbench for the rc pulse capture block: scoreboard class, word drivers and checks
module testbench;

  localparam int NCH         = rpc_pkg::CHANNELS_DEFAULT;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 200;

  class pulse_width_tracker;
    rpc_pkg::cfg_t                 cfg;
    logic [rpc_pkg::VAL_W-1:0]     chan_val [NCH];
    logic [rpc_pkg::PORT_W-1:0]    cur_ch;
    logic [rpc_pkg::PORT_W-1:0]    seen_ch;
    logic                          await_rise;
    logic [rpc_pkg::CAP_W-1:0]     rise_time;
    logic [rpc_pkg::TICK_W-1:0]    idle_ticks;
    rpc_pkg::out_word_t            pending_results [$];
    int                            errors;

    function new();
      cfg.timeout_ticks    = rpc_pkg::TIMEOUT_RESET;
      cfg.min_accept       = rpc_pkg::MIN_RESET;
      cfg.max_accept       = rpc_pkg::MAX_RESET;
      cfg.throttle_default = rpc_pkg::THROTTLE_RESET;
      cfg.center_default   = rpc_pkg::CENTER_RESET;
      cfg.throttle_channel = rpc_pkg::THR_CH_RESET;
      foreach (chan_val[i]) chan_val[i] = rpc_pkg::CENTER_RESET;
      chan_val[1] = '0;
      cur_ch     = '0;
      seen_ch    = '0;
      await_rise = 1'b1;
      rise_time  = '0;
      idle_ticks = '0;
      errors     = 0;
    endfunction

    function logic [rpc_pkg::PORT_W-1:0] advance(logic [rpc_pkg::PORT_W-1:0] ch);
      return (int'(ch) == NCH - 1) ? '0 : ch + 1'b1;
    endfunction

    function void set_reg(rpc_pkg::reg_idx_t idx, logic [rpc_pkg::DATA_W-1:0] v);
      unique case (idx)
        rpc_pkg::REG_TIMEOUT_TICKS:    cfg.timeout_ticks    = v[rpc_pkg::TICK_W-1:0];
        rpc_pkg::REG_MIN_ACCEPT:       cfg.min_accept       = v[rpc_pkg::VAL_W-1:0];
        rpc_pkg::REG_MAX_ACCEPT:       cfg.max_accept       = v[rpc_pkg::VAL_W-1:0];
        rpc_pkg::REG_THROTTLE_DEFAULT: cfg.throttle_default = v[rpc_pkg::VAL_W-1:0];
        rpc_pkg::REG_CENTER_DEFAULT:   cfg.center_default   = v[rpc_pkg::VAL_W-1:0];
        rpc_pkg::REG_THROTTLE_CHANNEL: cfg.throttle_channel = v[rpc_pkg::PORT_W-1:0];
        default: ;
      endcase
    endfunction

    // accepted input word: advance the model and queue the result it causes
    function void log_input(rpc_pkg::in_word_t w);
      rpc_pkg::out_word_t        r;
      logic [rpc_pkg::CAP_W-1:0] span;
      logic [rpc_pkg::CAP_W-1:0] half;
      logic [rpc_pkg::VAL_W-1:0] dflt;
      r = '0;
      if (w.opcode == rpc_pkg::OP_CAPTURE) begin
        if (await_rise) begin
          rise_time  = w.capture_time;
          await_rise = 1'b0;
        end else begin
          span = w.capture_time - rise_time;
          half = span >> 1;
          if (half <= cfg.max_accept && half > cfg.min_accept) begin
            chan_val[cur_ch]  = half[rpc_pkg::VAL_W-1:0];
            r.stored          = 1'b1;
            r.written_channel = cur_ch;
            r.width_us        = half[rpc_pkg::VAL_W-1:0];
            cur_ch            = advance(cur_ch);
          end
          await_rise = 1'b1;
        end
      end else if (seen_ch != cur_ch) begin
        idle_ticks = '0;
        seen_ch    = cur_ch;
      end else begin
        idle_ticks = idle_ticks + 1'b1;
        if (idle_ticks > cfg.timeout_ticks) begin
          dflt = (cur_ch == cfg.throttle_channel) ? cfg.throttle_default : cfg.center_default;
          chan_val[cur_ch]  = dflt;
          r.stored          = 1'b1;
          r.timed_out       = 1'b1;
          r.written_channel = cur_ch;
          r.width_us        = dflt;
          cur_ch            = advance(cur_ch);
          await_rise        = 1'b1;
        end
      end
      r.mux_select   = cur_ch;
      r.await_rising = await_rise;
      pending_results.push_back(r);
    endfunction

    function void flag(string msg);
      if (errors < 10) $display("mismatch: %s", msg);
      errors++;
    endfunction

    function void check_result(rpc_pkg::out_word_t got);
      rpc_pkg::out_word_t want;
      if (pending_results.size() == 0) begin
        flag($sformatf("result word with nothing pending: %h", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.stored !== want.stored || got.written_channel !== want.written_channel ||
          got.width_us !== want.width_us || got.mux_select !== want.mux_select ||
          got.timed_out !== want.timed_out || got.await_rising !== want.await_rising)
        flag($sformatf({"expected stored=%0d ch=%0d width=%0d mux=%0d tout=%0d rise=%0d, ",
                        "got stored=%0d ch=%0d width=%0d mux=%0d tout=%0d rise=%0d"},
                       want.stored, want.written_channel, want.width_us, want.mux_select,
                       want.timed_out, want.await_rising, got.stored, got.written_channel,
                       got.width_us, got.mux_select, got.timed_out, got.await_rising));
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  rpc_pkg::in_word_t            in_word;
  logic                         out_valid;
  logic                         out_ready;
  rpc_pkg::out_word_t           out_word;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [rpc_pkg::ADDR_W-1:0]   paddr;
  logic [rpc_pkg::DATA_W-1:0]   pwdata;
  logic [rpc_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  pulse_width_tracker  tracker;
  bit                  no_gaps;
  bit                  hold_req;
  int                  cycles;

  rc_pulse_capture_with_timeout_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[rc_pulse_capture_with_timeout_core] ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 80) return $urandom_range(1, 3);
    if (k < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // result side stalls, including the long hold-off that fills the block
  initial begin : ready_ctrl
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
        stall_left = pick_gap() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_result(out_word);
  end

  task automatic push_word(input rpc_pkg::opcode_t op,
                           input logic [rpc_pkg::CAP_W-1:0] t);
    rpc_pkg::in_word_t w;
    int                gap;
    w.opcode       = op;
    w.capture_time = t;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    tracker.log_input(w);
    gap = (no_gaps || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input rpc_pkg::reg_idx_t idx,
                           input logic [rpc_pkg::DATA_W-1:0] value);
    logic [rpc_pkg::DATA_W-1:0] keep;
    logic [rpc_pkg::DATA_W-1:0] data;
    unique case (idx)
      rpc_pkg::REG_TIMEOUT_TICKS:    keep = 32'h0000_00ff;
      rpc_pkg::REG_THROTTLE_CHANNEL: keep = 32'h0000_0003;
      default:                       keep = 32'h0000_0fff;
    endcase
    // junk above the field width must be dropped by the block
    data = (value & keep) | ($urandom & ~keep);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic program_regs(input int tmo, input int lo, input int hi, input int thr,
                              input int ctr, input int thr_ch);
    write_reg(rpc_pkg::REG_TIMEOUT_TICKS, tmo);
    write_reg(rpc_pkg::REG_MIN_ACCEPT, lo);
    write_reg(rpc_pkg::REG_MAX_ACCEPT, hi);
    write_reg(rpc_pkg::REG_THROTTLE_DEFAULT, thr);
    write_reg(rpc_pkg::REG_CENTER_DEFAULT, ctr);
    write_reg(rpc_pkg::REG_THROTTLE_CHANNEL, thr_ch);
  endtask

  // mostly rising/falling pairs, plus tick bursts and stray words
  task automatic run_random(input int n);
    int                        i;
    int                        k;
    int                        lo;
    int                        hi;
    int                        w;
    int                        len;
    int                        next_toggle;
    logic [rpc_pkg::CAP_W-1:0] rise;
    i = 0;
    next_toggle = 64;
    while (i < n) begin
      if (i >= next_toggle) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        next_toggle += 64;
      end
      k = $urandom_range(0, 99);
      if (k < 60) begin
        if (!tracker.await_rise) begin
          push_word(rpc_pkg::OP_CAPTURE, rpc_pkg::CAP_W'($urandom));
          i++;
        end
        lo = int'(tracker.cfg.min_accept);
        hi = int'(tracker.cfg.max_accept);
        k = $urandom_range(0, 99);
        if (k < 70 && hi > lo) begin
          w = $urandom_range(lo + 1, hi);
        end else if (k < 85) begin
          case ($urandom_range(0, 3))
            0:       w = lo;
            1:       w = lo + 1;
            2:       w = hi;
            default: w = hi + 1;
          endcase
        end else begin
          w = $urandom_range(0, 32767);
        end
        rise = rpc_pkg::CAP_W'($urandom);
        push_word(rpc_pkg::OP_CAPTURE, rise);
        push_word(rpc_pkg::OP_CAPTURE, rpc_pkg::CAP_W'(rise + 2 * w + $urandom_range(0, 1)));
        i += 2;
      end else if (k < 85) begin
        len = int'(tracker.cfg.timeout_ticks) + 3;
        if (len > 20) len = 20;
        len = $urandom_range(1, len);
        repeat (len) push_word(rpc_pkg::OP_TICK, rpc_pkg::CAP_W'($urandom));
        i += len;
      end else begin
        push_word(k[0] ? rpc_pkg::OP_TICK : rpc_pkg::OP_CAPTURE, rpc_pkg::CAP_W'($urandom));
        i++;
      end
    end
  endtask

  initial begin
    int lo;
    tracker  = new();
    no_gaps  = 1'b0;
    hold_req = 1'b0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_word  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed words at reset settings
    push_word(rpc_pkg::OP_TICK, 16'h0000);
    push_word(rpc_pkg::OP_CAPTURE, 16'hfff0);
    push_word(rpc_pkg::OP_CAPTURE, 16'hfff0 + 16'd3000);
    push_word(rpc_pkg::OP_CAPTURE, 16'd0);
    push_word(rpc_pkg::OP_CAPTURE, 16'd1802);
    push_word(rpc_pkg::OP_CAPTURE, 16'd100);
    push_word(rpc_pkg::OP_CAPTURE, 16'd1901);
    push_word(rpc_pkg::OP_CAPTURE, 16'd0);
    push_word(rpc_pkg::OP_CAPTURE, 16'd4101);
    push_word(rpc_pkg::OP_CAPTURE, 16'd0);
    push_word(rpc_pkg::OP_CAPTURE, 16'd4102);
    push_word(rpc_pkg::OP_CAPTURE, 16'hffff);
    push_word(rpc_pkg::OP_CAPTURE, 16'hffff);
    push_word(rpc_pkg::OP_CAPTURE, 16'h0000);
    push_word(rpc_pkg::OP_CAPTURE, 16'hffff);
    push_word(rpc_pkg::OP_CAPTURE, 16'h1234);
    repeat (7) push_word(rpc_pkg::OP_TICK, 16'hffff);
    push_word(rpc_pkg::OP_CAPTURE, 16'h0000);
    run_random(150);

    settle();
    program_regs(0, 0, 4095, 4095, 0, 3);
    run_random(150);

    settle();
    program_regs(255, 4095, 0, 0, 4095, 0);
    run_random(60);

    settle();
    lo = $urandom_range(0, 1200);
    program_regs($urandom_range(0, 8), lo, $urandom_range(lo, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 3));
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    run_random(180);

    settle();
    lo = $urandom_range(0, 1200);
    program_regs($urandom_range(0, 8), lo, $urandom_range(lo, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 3));
    run_random(200);

    settle();
    lo = $urandom_range(0, 1200);
    program_regs($urandom_range(0, 8), lo, $urandom_range(lo, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 3));
    run_random(200);

    settle();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("[rc_pulse_capture_with_timeout_core] OK");
    end else begin
      $display("[rc_pulse_capture_with_timeout_core] ERROR");
    end
    $finish;
  end

endmodule
